// File: design/tagged_value_stream_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Tagged value stream decoder assertion macros
// Shared concurrent assertion forms for the decoder's own checks.
// ----------------------------------------------------------------------------
`ifndef TAGGED_VALUE_STREAM_DECODER_UNIT_MACROS_SVH
`define TAGGED_VALUE_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TVSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TVSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tvsd_pkg.sv
// ----------------------------------------------------------------------------
// Tagged value stream decoder package
// Tag bytes, result kinds, error causes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tvsd_pkg;

    localparam logic [7:0] TAG_STR  = 8'h74;
    localparam logic [7:0] TAG_WORD = 8'h4C;
    localparam logic [7:0] TAG_BYTE = 8'h42;
    localparam logic [7:0] TAG_SPEC = 8'h61;

    localparam logic [2:0] KIND_CHAR  = 3'd0;
    localparam logic [2:0] KIND_END   = 3'd1;
    localparam logic [2:0] KIND_WORD  = 3'd2;
    localparam logic [2:0] KIND_BYTE  = 3'd3;
    localparam logic [2:0] KIND_SPEC  = 3'd4;
    localparam logic [2:0] KIND_ERROR = 3'd5;

    localparam logic [1:0] CAUSE_UNKNOWN_TAG  = 2'd0;
    localparam logic [1:0] CAUSE_TRUNCATED    = 2'd1;
    localparam logic [1:0] CAUSE_UNTERMINATED = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [31:0] value;
        logic [7:0]  sample_format;
        logic [7:0]  channel_count;
        logic [1:0]  error_cause;
    } result_t;

endpackage

`default_nettype wire

// File: design/tvsd_core.sv
// ----------------------------------------------------------------------------
// Tagged value stream decoder core
// Holds the parse state and turns one byte into at most one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvsd_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_final,
    output tvsd_pkg::result_t      res
);

    localparam logic [2:0] PH_TAG  = 3'd0;
    localparam logic [2:0] PH_STR  = 3'd1;
    localparam logic [2:0] PH_WORD = 3'd2;
    localparam logic [2:0] PH_BYTE = 3'd3;
    localparam logic [2:0] PH_FMT  = 3'd4;
    localparam logic [2:0] PH_CHAN = 3'd5;
    localparam logic [2:0] PH_RATE = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  bytes_left_reg, bytes_left_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  format_reg, format_next;
    logic [7:0]  channels_reg, channels_next;
    logic        dropping_reg, dropping_next;

    always_comb begin
        logic [31:0] acc_shift;
        logic [2:0]  bytes_dec;
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        format_next     = format_reg;
        channels_next   = channels_reg;
        dropping_next   = dropping_reg;
        res             = '0;
        acc_shift       = {acc_reg[23:0], in_byte};
        bytes_dec       = (bytes_left_reg != 3'd0) ? bytes_left_reg - 3'd1 : 3'd0;

        if (step_en) begin
            if (dropping_reg) begin
                if (in_final) begin
                    dropping_next   = 1'b0;
                    phase_next      = PH_TAG;
                    bytes_left_next = 3'd0;
                end
            end else begin
                case (phase_reg)
                    PH_STR: begin
                        if (in_byte == 8'd0) begin
                            phase_next = PH_TAG;
                            res.valid  = 1'b1;
                            res.kind   = tvsd_pkg::KIND_END;
                        end else if (in_final) begin
                            phase_next      = PH_TAG;
                            bytes_left_next = 3'd0;
                            res.valid       = 1'b1;
                            res.kind        = tvsd_pkg::KIND_ERROR;
                            res.error_cause = tvsd_pkg::CAUSE_UNTERMINATED;
                        end else begin
                            res.valid = 1'b1;
                            res.kind  = tvsd_pkg::KIND_CHAR;
                            res.value = {24'd0, in_byte};
                        end
                    end
                    PH_BYTE: begin
                        phase_next = PH_TAG;
                        res.valid  = 1'b1;
                        res.kind   = tvsd_pkg::KIND_BYTE;
                        res.value  = {24'd0, in_byte};
                    end
                    PH_FMT, PH_CHAN: begin
                        if (phase_reg == PH_FMT) begin
                            format_next = in_byte;
                        end else begin
                            channels_next = in_byte;
                        end
                        if (in_final) begin
                            phase_next      = PH_TAG;
                            bytes_left_next = 3'd0;
                            res.valid       = 1'b1;
                            res.kind        = tvsd_pkg::KIND_ERROR;
                            res.error_cause = tvsd_pkg::CAUSE_TRUNCATED;
                        end else if (phase_reg == PH_FMT) begin
                            phase_next = PH_CHAN;
                        end else begin
                            phase_next      = PH_RATE;
                            bytes_left_next = 3'd4;
                            acc_next        = 32'd0;
                        end
                    end
                    PH_WORD, PH_RATE: begin
                        acc_next        = acc_shift;
                        bytes_left_next = bytes_dec;
                        if (bytes_dec == 3'd0) begin
                            phase_next = PH_TAG;
                            res.valid  = 1'b1;
                            res.value  = acc_shift;
                            if (phase_reg == PH_WORD) begin
                                res.kind = tvsd_pkg::KIND_WORD;
                            end else begin
                                res.kind          = tvsd_pkg::KIND_SPEC;
                                res.sample_format = format_reg;
                                res.channel_count = channels_reg;
                            end
                        end else if (in_final) begin
                            phase_next      = PH_TAG;
                            bytes_left_next = 3'd0;
                            res.valid       = 1'b1;
                            res.kind        = tvsd_pkg::KIND_ERROR;
                            res.error_cause = tvsd_pkg::CAUSE_TRUNCATED;
                        end
                    end
                    default: begin
                        phase_next = PH_TAG;
                        if (!(in_byte inside {tvsd_pkg::TAG_STR, tvsd_pkg::TAG_WORD,
                                              tvsd_pkg::TAG_BYTE, tvsd_pkg::TAG_SPEC})) begin
                            bytes_left_next = 3'd0;
                            dropping_next   = !in_final;
                            res.valid       = 1'b1;
                            res.kind        = tvsd_pkg::KIND_ERROR;
                            res.error_cause = tvsd_pkg::CAUSE_UNKNOWN_TAG;
                        end else if (in_final) begin
                            bytes_left_next = 3'd0;
                            res.valid       = 1'b1;
                            res.kind        = tvsd_pkg::KIND_ERROR;
                            res.error_cause = tvsd_pkg::CAUSE_TRUNCATED;
                        end else if (in_byte == tvsd_pkg::TAG_STR) begin
                            phase_next = PH_STR;
                        end else if (in_byte == tvsd_pkg::TAG_WORD) begin
                            phase_next      = PH_WORD;
                            bytes_left_next = 3'd4;
                            acc_next        = 32'd0;
                        end else if (in_byte == tvsd_pkg::TAG_BYTE) begin
                            phase_next = PH_BYTE;
                        end else begin
                            phase_next = PH_FMT;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_TAG;
            bytes_left_reg <= 3'd0;
            acc_reg        <= 32'd0;
            format_reg     <= 8'd0;
            channels_reg   <= 8'd0;
            dropping_reg   <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            format_reg     <= format_next;
            channels_reg   <= channels_next;
            dropping_reg   <= dropping_next;
        end
    end

endmodule

`default_nettype wire

// File: design/tagged_value_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// Tagged value stream decoder
// Decodes tagged strings, words, bytes and sample specs from a byte stream.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_in_byte, s_final_byte
// m_        out        m_valid/m_ready    m_kind, m_value, m_sample_format,
//                                         m_channel_count, m_error_cause
//
// One byte is accepted per cycle unless a stalled result backs up a full input
// register; its result, if any, passes the input register, then the result register.
// Reset is synchronous and active low and returns the parser to a tag byte.
// A stalled result holds both registers; the input side keeps accepting while
// the input register is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tagged_value_stream_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_final_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic [31:0]      m_value,
    output logic [7:0]       m_sample_format,
    output logic [7:0]       m_channel_count,
    output logic [1:0]       m_error_cause
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_final_reg;
    logic              out_valid_reg;
    tvsd_pkg::result_t out_reg;
    tvsd_pkg::result_t step_res;
    logic              advance;
    logic              step_en;

    assign advance = !out_valid_reg || m_ready;
    assign step_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    tvsd_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .in_byte  (in_byte_reg),
        .in_final (in_final_reg),
        .res      (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= step_en && step_res.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_in_byte;
            in_final_reg <= s_final_byte;
        end
        if (step_en) begin
            out_reg <= step_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_value         = out_reg.value;
    assign m_sample_format = out_reg.sample_format;
    assign m_channel_count = out_reg.channel_count;
    assign m_error_cause   = out_reg.error_cause;

`include "tagged_value_stream_decoder_unit_macros.svh"

    `TVSD_ASSERT_SAME(a_ready_only_stalled, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without an output stall")
    `TVSD_ASSERT_SAME(a_kind_range, aclk, aresetn, m_valid, m_kind <= tvsd_pkg::KIND_ERROR, "result kind out of range")
    `TVSD_ASSERT_SAME(a_cause_only_error, aclk, aresetn, m_valid && (m_kind != tvsd_pkg::KIND_ERROR), m_error_cause == tvsd_pkg::CAUSE_UNKNOWN_TAG, "error cause set on a non-error result")
    `TVSD_ASSERT_SAME(a_value_zero, aclk, aresetn, m_valid && ((m_kind == tvsd_pkg::KIND_END) || (m_kind == tvsd_pkg::KIND_ERROR)), m_value == 32'd0, "value set on a string end or error result")
    `TVSD_ASSERT_NEXT(a_transfer_drains, aclk, aresetn, m_valid && m_ready && !in_valid_reg, !m_valid, "result repeated after its transfer")

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Tagged value stream decoder testbench
// Sends tagged messages byte by byte, predicts every decoded value and error
// in lockstep, and compares each result transfer against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import tvsd_pkg::*;

    localparam int STREAM_BYTES = 560;
    localparam int CALM_BYTES   = 60;
    localparam int LONG_HOLD    = 50;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 60000;

    typedef enum logic [2:0] {
        AWAIT_TAG, IN_STRING, IN_WORD, IN_BYTE, IN_FORMAT, IN_CHANNELS, IN_RATE
    } parse_phase_e;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [7:0]  sample_format;
        logic [7:0]  channel_count;
        logic [1:0]  error_cause;
    } decoded_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        s_final_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [31:0] m_value;
    logic [7:0]  m_sample_format;
    logic [7:0]  m_channel_count;
    logic [1:0]  m_error_cause;

    stream_byte_t pending_bytes[$];
    stream_byte_t next_byte;
    logic [7:0]   msg_bytes[$];
    decoded_t     decoded_q[$];
    decoded_t     want;

    parse_phase_e parse_phase = AWAIT_TAG;
    logic [2:0]   bytes_due = 3'd0;
    logic [31:0]  accum = 32'd0;
    logic [7:0]   held_fmt = 8'd0;
    logic [7:0]   held_chans = 8'd0;
    logic         skipping = 1'b0;

    int  cycle_count = 0;
    int  tx_gap = 0;
    int  rx_hold = 0;
    int  mismatches = 0;
    int  results_checked = 0;
    int  bytes_taken = 0;
    int  messages = 0;
    int  kind_tally[0:5] = '{default: 0};
    logic in_accepted = 1'b0;
    logic calm = 1'b0;
    wire  idle_window = ((cycle_count >> 6) % 3) != 0;

    tagged_value_stream_decoder_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_final_byte    (s_final_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_value         (m_value),
        .m_sample_format (m_sample_format),
        .m_channel_count (m_channel_count),
        .m_error_cause   (m_error_cause)
    );

    always #5 aclk = ~aclk;

    task push_decoded(input logic [2:0] kind, input logic [31:0] value,
                      input logic [7:0] fmt, input logic [7:0] chans);
        decoded_t d;
        d.kind = kind;
        d.value = value;
        d.sample_format = fmt;
        d.channel_count = chans;
        d.error_cause = '0;
        decoded_q.push_back(d);
        kind_tally[kind]++;
    endtask

    task push_error(input logic [1:0] cause, input logic last);
        decoded_t d;
        parse_phase = AWAIT_TAG;
        bytes_due = 3'd0;
        skipping = !last;
        d.kind = KIND_ERROR;
        d.value = '0;
        d.sample_format = '0;
        d.channel_count = '0;
        d.error_cause = cause;
        decoded_q.push_back(d);
        kind_tally[KIND_ERROR]++;
    endtask

    task decode_byte(input logic [7:0] b, input logic last);
        if (skipping) begin
            if (last) begin
                skipping = 1'b0;
                parse_phase = AWAIT_TAG;
                bytes_due = 3'd0;
            end
        end else begin
            case (parse_phase)
                IN_STRING: begin
                    if (b == 8'h00) begin
                        parse_phase = AWAIT_TAG;
                        push_decoded(KIND_END, '0, '0, '0);
                    end else if (last) begin
                        push_error(CAUSE_UNTERMINATED, 1'b1);
                    end else begin
                        push_decoded(KIND_CHAR, {24'd0, b}, '0, '0);
                    end
                end
                IN_BYTE: begin
                    parse_phase = AWAIT_TAG;
                    push_decoded(KIND_BYTE, {24'd0, b}, '0, '0);
                end
                IN_FORMAT: begin
                    held_fmt = b;
                    if (last) push_error(CAUSE_TRUNCATED, 1'b1);
                    else parse_phase = IN_CHANNELS;
                end
                IN_CHANNELS: begin
                    held_chans = b;
                    if (last) begin
                        push_error(CAUSE_TRUNCATED, 1'b1);
                    end else begin
                        parse_phase = IN_RATE;
                        bytes_due = 3'd4;
                        accum = '0;
                    end
                end
                IN_WORD, IN_RATE: begin
                    accum = {accum[23:0], b};
                    if (bytes_due != 0) bytes_due = bytes_due - 3'd1;
                    if (bytes_due == 0) begin
                        if (parse_phase == IN_WORD) push_decoded(KIND_WORD, accum, '0, '0);
                        else push_decoded(KIND_SPEC, accum, held_fmt, held_chans);
                        parse_phase = AWAIT_TAG;
                    end else if (last) begin
                        push_error(CAUSE_TRUNCATED, 1'b1);
                    end
                end
                default: begin
                    parse_phase = AWAIT_TAG;
                    if (b != TAG_STR && b != TAG_WORD && b != TAG_BYTE && b != TAG_SPEC) begin
                        push_error(CAUSE_UNKNOWN_TAG, last);
                    end else if (last) begin
                        push_error(CAUSE_TRUNCATED, 1'b1);
                    end else if (b == TAG_STR) begin
                        parse_phase = IN_STRING;
                    end else if (b == TAG_WORD) begin
                        parse_phase = IN_WORD;
                        bytes_due = 3'd4;
                        accum = '0;
                    end else if (b == TAG_BYTE) begin
                        parse_phase = IN_BYTE;
                    end else begin
                        parse_phase = IN_FORMAT;
                    end
                end
            endcase
        end
    endtask

    task log_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) $display("result %0d: %s", results_checked, what);
    endtask

    task put_byte(input logic [7:0] data, input logic last);
        stream_byte_t sb;
        sb.data = data;
        sb.last = last;
        pending_bytes.push_back(sb);
    endtask

    task add_value();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 3);
        case (pick)
            0: begin
                msg_bytes.push_back(TAG_STR);
                len = $urandom_range(0, 5);
                repeat (len) msg_bytes.push_back($urandom_range(1, 255));
                msg_bytes.push_back(8'h00);
            end
            1: begin
                msg_bytes.push_back(TAG_WORD);
                repeat (4) msg_bytes.push_back($urandom_range(0, 255));
            end
            2: begin
                msg_bytes.push_back(TAG_BYTE);
                msg_bytes.push_back($urandom_range(0, 255));
            end
            default: begin
                msg_bytes.push_back(TAG_SPEC);
                repeat (6) msg_bytes.push_back($urandom_range(0, 255));
            end
        endcase
    endtask

    task flush_message();
        for (int i = 0; i < msg_bytes.size(); i++) put_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
        messages++;
    endtask

    // Driver: holds a byte until its transfer, then offers the next one or idles.
    always @(negedge aclk) begin
        calm <= pending_bytes.size() < CALM_BYTES;
        if (aresetn && !(s_valid && !in_accepted)) begin
            if (tx_gap != 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_bytes.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!calm && idle_window && $urandom_range(0, 5) == 0) begin
                tx_gap = $urandom_range(0, 2);
                s_valid <= 1'b0;
            end else begin
                next_byte = pending_bytes.pop_front();
                s_valid <= 1'b1;
                s_in_byte <= next_byte.data;
                s_final_byte <= next_byte.last;
            end
        end
    end

    // Receiver: short random stalls plus two long holds that back up the block.
    always @(negedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (aresetn && !calm && (cycle_count == 150 || cycle_count == 450)) begin
            rx_hold = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (aresetn && !calm && idle_window && $urandom_range(0, 4) == 0) begin
            rx_hold = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predicts on each input transfer and checks each result transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_accepted <= 1'b0;
        end else begin
            in_accepted <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                bytes_taken++;
                decode_byte(s_in_byte, s_final_byte);
            end
            if (m_valid && m_ready) begin
                results_checked++;
                if (decoded_q.size() == 0) begin
                    log_mismatch($sformatf("unexpected result, kind %0d value %h",
                                           m_kind, m_value));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_kind !== want.kind)
                        log_mismatch($sformatf("kind %0d, expected %0d", m_kind, want.kind));
                    if (m_value !== want.value)
                        log_mismatch($sformatf("value %h, expected %h", m_value, want.value));
                    if (m_sample_format !== want.sample_format)
                        log_mismatch($sformatf("sample_format %h, expected %h",
                                               m_sample_format, want.sample_format));
                    if (m_channel_count !== want.channel_count)
                        log_mismatch($sformatf("channel_count %h, expected %h",
                                               m_channel_count, want.channel_count));
                    if (m_error_cause !== want.error_cause)
                        log_mismatch($sformatf("error_cause %0d, expected %0d",
                                               m_error_cause, want.error_cause));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tagged_value_stream_decoder_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        int unsigned cut;
        int unsigned count;

        // Directed messages: field extremes, every value type and every error path.
        put_byte(TAG_WORD, 1'b0);
        repeat (4) put_byte(8'hFF, 1'b0);
        put_byte(TAG_BYTE, 1'b0);
        put_byte(8'h00, 1'b1);
        put_byte(TAG_STR, 1'b0);
        put_byte(8'h41, 1'b0);
        put_byte(8'h00, 1'b1);
        put_byte(TAG_SPEC, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h12, 1'b0);
        put_byte(8'h34, 1'b0);
        put_byte(8'h56, 1'b0);
        put_byte(8'h78, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(TAG_STR, 1'b0);
        put_byte(TAG_WORD, 1'b1);
        put_byte(TAG_BYTE, 1'b1);
        put_byte(TAG_STR, 1'b0);
        put_byte(8'h80, 1'b1);
        put_byte(TAG_WORD, 1'b0);
        put_byte(8'h01, 1'b0);
        put_byte(8'h02, 1'b1);
        put_byte(8'hFF, 1'b1);
        messages = 8;

        // Random messages, mostly well formed, some corrupted, cut short or padded.
        while (pending_bytes.size() < STREAM_BYTES) begin
            count = $urandom_range(1, 4);
            repeat (count) add_value();
            r = $urandom_range(0, 99);
            if (r < 10) begin
                msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = $urandom_range(0, 255);
            end else if (r < 22) begin
                cut = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
            end else if (r < 27) begin
                count = $urandom_range(1, 3);
                repeat (count) msg_bytes.push_back($urandom_range(0, 255));
            end
            flush_message();
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d bytes in %0d messages, checked %0d results in %0d cycles",
                 bytes_taken, messages, results_checked, cycle_count);
        $display("by kind: char %0d, end %0d, word %0d, byte %0d, spec %0d, error %0d",
                 kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3],
                 kind_tally[4], kind_tally[5]);
        if (mismatches == 0) begin
            $display("tagged_value_stream_decoder_unit: match");
        end else begin
            $display("tagged_value_stream_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: tagged_value_stream_decoder_unit.f
+incdir+design
design/tvsd_pkg.sv
design/tvsd_core.sv
design/tagged_value_stream_decoder_unit.sv
verif/tb.sv
